// ----- sv/tsp_pkg.sv -----
`default_nettype none
package tsp_pkg;

    // Fraction bits of every fixed-point quantity.
    localparam int FRAC_BITS = 16;

    // Field widths of the configuration registers and the words.
    localparam int TW = 32;
    localparam int UW = 31;
    localparam int CFG_IDX_W = 3;

    // Cap on every intermediate product after its shift.
    localparam int CAP_W = 39;
    localparam logic [CAP_W-1:0] BIG_CAP = {1'b1, {(CAP_W-1){1'b0}}};

    // Width of the signed working values ahead of saturation.
    localparam int SW = 43;

    // Stages of the remainder unit, one quotient bit each.
    localparam int DIV_STAGES = TW;

    // Motion phases within one half cycle.
    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_REST   = 2'd3
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_WAY_TIME   = 3'd0,
        CFG_ACCEL_TIME     = 3'd1,
        CFG_CRUISE_TIME    = 3'd2,
        CFG_MAX_ACCEL      = 3'd3,
        CFG_MAX_SPEED      = 3'd4,
        CFG_ACCEL_DISTANCE = 3'd5,
        CFG_PATH_LENGTH    = 3'd6,
        CFG_X_OFFSET       = 3'd7
    } t_cfg_idx;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [TW-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'(signed'({1'b0, {(TW-1){1'b1}}}));
        lo = -hi - SW'(signed'(1));
        if (v > hi) begin
            sat32 = {1'b0, {(TW-1){1'b1}}};
        end else if (v < lo) begin
            sat32 = {1'b1, {(TW-1){1'b0}}};
        end else begin
            sat32 = v[TW-1:0];
        end
    endfunction

    // Shift a product right and clamp it at the cap.
    function automatic logic [CAP_W-1:0] cap_shift(input logic [71:0] p, input int sh);
        logic [71:0] t;
        t = p >> sh;
        if (t > 72'(BIG_CAP)) begin
            cap_shift = BIG_CAP;
        end else begin
            cap_shift = t[CAP_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/trapezoid_shuttle_profile_core.sv -----
`default_nettype none
// Back-and-forth trapezoidal motion profile evaluator.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high;
// stages read the registers directly, so a write also reaches words in flight.
// The user must change them only while no word is in flight; nothing checks it.
// Input: a sample time word is taken at each clock edge where start is high;
// busy is always low, so one word can be taken in every cycle.
// Output: o_result_valid is high for exactly one cycle with the result word;
// the receiver cannot hold results off and none is needed.
// The remainder unit (one quotient bit per stage against twice the one-way
// time) is followed by seven stages for phase select, the first multiplier
// rank, scaling, the second rank, the join, the per-phase combine and the
// final saturation; the result word is registered in the last stage.
// Throughput: one word per cycle, set by the fully pipelined remainder unit
// and multipliers.
// Reset: synchronous, active low; clears all valid bits and the configuration registers.
module trapezoid_shuttle_profile_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [tsp_pkg::TW-1:0]           i_sample_time,
    input  wire                              i_cfg_we,
    input  wire  [tsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [tsp_pkg::TW-1:0]           i_cfg_data,
    output logic                             o_result_valid,
    output logic                             o_reverse_dir,
    output logic [1:0]                       o_phase,
    output logic [tsp_pkg::UW-1:0]           o_half_cycle_time,
    output logic signed [tsp_pkg::TW-1:0]    o_path_position,
    output logic signed [tsp_pkg::TW-1:0]    o_x_position,
    output logic signed [tsp_pkg::TW-1:0]    o_velocity,
    output logic signed [tsp_pkg::TW-1:0]    o_acceleration
);
    import tsp_pkg::*;

    // Configuration registers.
    logic [UW-1:0]        r_one_way_time, r_accel_time, r_cruise_time;
    logic [UW-1:0]        r_max_accel, r_max_speed, r_accel_distance, r_path_length;
    logic signed [TW-1:0] r_x_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_way_time   <= '0;
            r_accel_time     <= '0;
            r_cruise_time    <= '0;
            r_max_accel      <= '0;
            r_max_speed      <= '0;
            r_accel_distance <= '0;
            r_path_length    <= '0;
            r_x_offset       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ONE_WAY_TIME:   r_one_way_time   <= i_cfg_data[UW-1:0];
                CFG_ACCEL_TIME:     r_accel_time     <= i_cfg_data[UW-1:0];
                CFG_CRUISE_TIME:    r_cruise_time    <= i_cfg_data[UW-1:0];
                CFG_MAX_ACCEL:      r_max_accel      <= i_cfg_data[UW-1:0];
                CFG_MAX_SPEED:      r_max_speed      <= i_cfg_data[UW-1:0];
                CFG_ACCEL_DISTANCE: r_accel_distance <= i_cfg_data[UW-1:0];
                CFG_PATH_LENGTH:    r_path_length    <= i_cfg_data[UW-1:0];
                CFG_X_OFFSET:       r_x_offset       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Remainder unit: restoring steps against twice the one-way time.
    logic [TW-1:0] r_rem   [0:DIV_STAGES];
    logic          r_dvld  [0:DIV_STAGES];
    logic [TW-1:0] n_rem   [0:DIV_STAGES-1];
    logic [63:0]   n_shd   [0:DIV_STAGES-1];
    logic [TW-1:0] divisor;

    assign divisor = {r_one_way_time, 1'b0};

    // Each stage tries one shifted copy of the divisor.
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_shd[k] = {32'b0, divisor} << (DIV_STAGES - 1 - k);
            if ({32'b0, r_rem[k]} >= n_shd[k]) begin
                n_rem[k] = r_rem[k] - n_shd[k][TW-1:0];
            end else begin
                n_rem[k] = r_rem[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_sample_time;
        for (int k = 0; k < DIV_STAGES; k++) begin
            r_rem[k+1] <= n_rem[k];
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else begin
            r_dvld[0] <= start;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dvld[k+1] <= r_dvld[k];
            end
        end
    end

    // Stage 1: half-cycle time, direction, phase and multiplier operands.
    logic          r1_vld, r1_rev;
    t_phase        r1_ph;
    logic [UW-1:0] r1_n, r1_m, r1_lx, r1_ly;
    logic [TW-1:0] cyc, ow32, n_full, ac_sum;
    logic [UW-1:0] n1_n, n1_m, n1_lx, n1_ly;
    logic          n1_rev;
    t_phase        n1_ph;

    always_comb begin
        cyc    = r_rem[DIV_STAGES];
        ow32   = {1'b0, r_one_way_time};
        ac_sum = {1'b0, r_accel_time} + {1'b0, r_cruise_time};
        n1_rev = 1'b0;
        n_full = cyc;
        if (cyc >= ow32) begin
            n_full = cyc - ow32;
            n1_rev = 1'b1;
        end
        n1_n  = n_full[UW-1:0];
        n1_m  = n1_n;
        n1_lx = r_max_speed;
        n1_ly = n1_n - r_accel_time;
        if (r_one_way_time == '0) begin
            n1_ph  = PH_REST;
            n1_n   = '0;
            n1_rev = 1'b0;
        end else if ({1'b0, n1_n} < {1'b0, r_accel_time}) begin
            n1_ph = PH_ACCEL;
        end else if ({1'b0, n1_n} < ac_sum) begin
            n1_ph = PH_CRUISE;
        end else begin
            n1_ph = PH_DECEL;
            n1_m  = r_one_way_time - n1_n;
            n1_lx = r_max_accel;
            n1_ly = n1_n - r_accel_time - r_cruise_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rev <= n1_rev;
        r1_ph  <= n1_ph;
        r1_n   <= n1_n;
        r1_m   <= n1_m;
        r1_lx  <= n1_lx;
        r1_ly  <= n1_ly;
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r_dvld[DIV_STAGES];
        end
    end

    // Stage 2: the first rank of products.
    logic            r2_vld, r2_rev;
    t_phase          r2_ph;
    logic [UW-1:0]   r2_n, r2_m;
    logic [2*UW-1:0] r2_p, r2_lp;

    always_ff @(posedge i_clk) begin
        r2_rev <= r1_rev;
        r2_ph  <= r1_ph;
        r2_n   <= r1_n;
        r2_m   <= r1_m;
        r2_p   <= r_max_accel * r1_m;
        r2_lp  <= r1_lx * r1_ly;
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    // Stage 3: scale and cap the first products.
    logic             r3_vld, r3_rev;
    t_phase           r3_ph;
    logic [UW-1:0]    r3_n, r3_m;
    logic [CAP_W-1:0] r3_v1, r3_lin;

    always_ff @(posedge i_clk) begin
        r3_rev <= r2_rev;
        r3_ph  <= r2_ph;
        r3_n   <= r2_n;
        r3_m   <= r2_m;
        r3_v1  <= cap_shift(72'(r2_p), FRAC_BITS);
        r3_lin <= cap_shift(72'(r2_lp), FRAC_BITS);
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    // Stage 4: second rank, split in a low and a high partial product.
    logic             r4_vld, r4_rev;
    t_phase           r4_ph;
    logic [UW-1:0]    r4_n;
    logic [CAP_W-1:0] r4_v1, r4_lin;
    logic [2*UW-1:0]  r4_qlo;
    logic [CAP_W-1:0] r4_qhi;

    always_ff @(posedge i_clk) begin
        r4_rev <= r3_rev;
        r4_ph  <= r3_ph;
        r4_n   <= r3_n;
        r4_v1  <= r3_v1;
        r4_lin <= r3_lin;
        r4_qlo <= r3_v1[UW-1:0] * r3_m;
        r4_qhi <= CAP_W'(r3_v1[CAP_W-1:UW]) * CAP_W'(r3_m);
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    // Stage 5: join the partial products and take half of the square term.
    logic             r5_vld, r5_rev;
    t_phase           r5_ph;
    logic [UW-1:0]    r5_n;
    logic [CAP_W-1:0] r5_v1, r5_lin, r5_qs;
    logic [71:0]      n5_q;

    assign n5_q = ({33'b0, r4_qhi} << UW) + {10'b0, r4_qlo};

    always_ff @(posedge i_clk) begin
        r5_rev <= r4_rev;
        r5_ph  <= r4_ph;
        r5_n   <= r4_n;
        r5_v1  <= r4_v1;
        r5_lin <= r4_lin;
        r5_qs  <= cap_shift(n5_q, FRAC_BITS + 1);
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    // Stage 6: position, velocity and acceleration per phase, then mirroring.
    logic                 r6_vld, r6_rev;
    t_phase               r6_ph;
    logic [UW-1:0]        r6_n;
    logic signed [SW-1:0] r6_s, r6_v, r6_a;
    logic signed [SW-1:0] n6_s, n6_v, n6_a, len_s;

    always_comb begin
        len_s = SW'(signed'({1'b0, r_path_length}));
        unique case (r5_ph)
            PH_ACCEL: begin
                n6_s = SW'(signed'({1'b0, r5_qs}));
                n6_v = SW'(signed'({1'b0, r5_v1}));
                n6_a = SW'(signed'({1'b0, r_max_accel}));
            end
            PH_CRUISE: begin
                n6_s = SW'(signed'({1'b0, r_accel_distance}))
                     + SW'(signed'({1'b0, r5_lin}));
                n6_v = SW'(signed'({1'b0, r_max_speed}));
                n6_a = '0;
            end
            PH_DECEL: begin
                n6_s = len_s - SW'(signed'({1'b0, r5_qs}));
                n6_v = SW'(signed'({1'b0, r_max_speed}))
                     - SW'(signed'({1'b0, r5_lin}));
                n6_a = -SW'(signed'({1'b0, r_max_accel}));
            end
            default: begin
                n6_s = len_s;
                n6_v = '0;
                n6_a = '0;
            end
        endcase
        if (r5_rev) begin
            n6_s = len_s - n6_s;
            n6_v = -n6_v;
            n6_a = -n6_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_rev <= r5_rev;
        r6_ph  <= r5_ph;
        r6_n   <= r5_n;
        r6_s   <= n6_s;
        r6_v   <= n6_v;
        r6_a   <= n6_a;
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    // Stage 7: add the x offset and saturate into the output word.
    logic                 r7_vld, r7_rev;
    t_phase               r7_ph;
    logic [UW-1:0]        r7_n;
    logic signed [TW-1:0] r7_s, r7_x, r7_v, r7_a;

    always_ff @(posedge i_clk) begin
        r7_rev <= r6_rev;
        r7_ph  <= r6_ph;
        r7_n   <= r6_n;
        r7_s   <= sat32(r6_s);
        r7_x   <= sat32(r6_s + SW'(r_x_offset));
        r7_v   <= sat32(r6_v);
        r7_a   <= sat32(r6_a);
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    assign o_result_valid    = r7_vld;
    assign o_reverse_dir     = r7_rev;
    assign o_phase           = r7_ph;
    assign o_half_cycle_time = r7_n;
    assign o_path_position   = r7_s;
    assign o_x_position      = r7_x;
    assign o_velocity        = r7_v;
    assign o_acceleration    = r7_a;

`ifndef SYNTH
    // A zero one-way time always gives a forward word at rest.
    a_zero_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_one_way_time == '0)
            |-> (o_phase == PH_REST && !o_reverse_dir && o_half_cycle_time == '0))
        else $error("zero one-way time did not give the rest phase");

    // The rest phase only occurs with a zero one-way time.
    a_rest_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_phase == PH_REST) |-> (r_one_way_time == '0))
        else $error("rest phase with a nonzero one-way time");

    // Cruise and rest words carry no acceleration.
    a_no_accel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_phase == PH_CRUISE || o_phase == PH_REST))
            |-> (o_acceleration == '0))
        else $error("acceleration nonzero in cruise or rest");

    // The half-cycle time stays below the one-way time when a cycle exists.
    a_time_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_one_way_time != '0)
            |-> (o_half_cycle_time < r_one_way_time))
        else $error("half-cycle time out of range");
`endif

endmodule
`default_nettype wire
